>>> hw/rtl/fba_pkg.sv
`timescale 1ns / 1ps

package fba_pkg;

  localparam int MAX_FRAMES = 4096;
  localparam int WORD_BITS  = 32;
  localparam int WORD_COUNT = MAX_FRAMES / WORD_BITS;
  localparam int WORD_AW    = $clog2(WORD_COUNT);
  localparam int BIT_AW     = $clog2(WORD_BITS);
  localparam int FRAME_W    = WORD_AW + BIT_AW;
  localparam int NF_W       = 13;
  localparam int LIMIT_W    = NF_W - BIT_AW;

  localparam logic [WORD_BITS-1:0] FULL_WORD        = '1;
  localparam logic [NF_W-1:0]      NUM_FRAMES_RESET = NF_W'(MAX_FRAMES);
  localparam logic [LIMIT_W-1:0]   LIMIT_MAX        = LIMIT_W'(WORD_COUNT);

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_ALLOCATED = 3'd0,
    ST_HAD_FRAME = 3'd1,
    ST_FREED     = 3'd2,
    ST_NOTHING   = 3'd3,
    ST_NO_FREE   = 3'd4
  } status_t;

  // Lowest clear bit of a word that is not full, by halving the window.
  function automatic logic [BIT_AW-1:0] first_zero(input logic [WORD_BITS-1:0] word);
    logic [WORD_BITS-1:0] inv;
    logic [BIT_AW-1:0]    pos;
    inv = ~word;
    pos = '0;
    for (int s = BIT_AW - 1; s >= 0; s--) begin
      if ((inv & ((WORD_BITS'(1) << (1 << s)) - WORD_BITS'(1))) == '0) begin
        pos[s] = 1'b1;
        inv    = inv >> (1 << s);
      end
    end
    return pos;
  endfunction

endpackage

>>> hw/rtl/frame_bitmap_allocator_core.sv
`timescale 1ns / 1ps
// Path: an allocate into an entry that already holds a frame, a free of frame zero, or an
//   allocate with no words to search goes to S_DONE; a free first passes S_FREE; an allocate
//   scans words 0 up to limit-1, limit = min(num_frames/32, 128), stopping at a clear bit.
// Throughput: one request at a time; the next is taken once S_DONE loads the result, and
//   a result still waiting on out_ready holds the block. The scan reads one word per cycle.
// Reset (rst, synchronous): every frame free via per-word valid bits, num_frames = 4096,
//   no result pending. No clearing pass is needed.
module frame_bitmap_allocator_core (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic [12:0] cfg_wdata,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [11:0] page_frame,
  input  logic        is_kernel,
  input  logic        is_writeable,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [11:0] frame_index,
  output logic        present,
  output logic        writable,
  output logic        user_bit
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FREE,
    S_DONE
  } state_t;

  state_t state;

  // Configuration register
  logic [fba_pkg::NF_W-1:0] num_frames;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_frames <= fba_pkg::NUM_FRAMES_RESET;
    end else if (cfg_we) begin
      num_frames <= cfg_wdata;
    end
  end

  // Searched word count, clamped to the bitmap depth
  logic [fba_pkg::LIMIT_W-1:0] nf_words;
  logic [fba_pkg::LIMIT_W-1:0] limit;

  assign nf_words = num_frames[fba_pkg::NF_W-1:fba_pkg::BIT_AW];
  assign limit    = (nf_words > fba_pkg::LIMIT_MAX) ? fba_pkg::LIMIT_MAX : nf_words;

  // Request and scan registers
  logic [fba_pkg::WORD_AW-1:0] chk_addr;   // word whose data sits in mem_q
  logic [fba_pkg::LIMIT_W-1:0] scan_addr;  // next word to read
  logic [fba_pkg::BIT_AW-1:0]  pf_bit;
  logic                        kern_q;
  logic                        wr_q;

  // Bitmap memory: one read and one write port, registered read data.
  // A word that was never written reads as all free through its valid bit.
  logic [fba_pkg::WORD_BITS-1:0] bitmap [fba_pkg::WORD_COUNT];
  logic [fba_pkg::WORD_COUNT-1:0] word_vld;
  logic [fba_pkg::WORD_AW-1:0]    rd_addr;
  logic [fba_pkg::WORD_BITS-1:0]  mem_q;
  logic                           vld_q;
  logic                           mem_we;
  logic [fba_pkg::WORD_BITS-1:0]  mem_wdata;
  logic [fba_pkg::WORD_BITS-1:0]  word;

  always_ff @(posedge clk) begin
    mem_q <= bitmap[rd_addr];
    if (mem_we) begin
      bitmap[chk_addr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_vld <= '0;
      vld_q    <= 1'b0;
    end else begin
      vld_q <= word_vld[rd_addr];
      if (mem_we) begin
        word_vld[chk_addr] <= 1'b1;
      end
    end
  end

  assign word = vld_q ? mem_q : '0;

  // Pending result, moved to the output register in S_DONE
  fba_pkg::status_t             res_status;
  logic [fba_pkg::FRAME_W-1:0]  res_frame;
  logic                         res_present;
  logic                         res_writable;
  logic                         res_user;

  // Scan decision on the word just read
  logic                       found;
  logic                       last_word;
  logic [fba_pkg::BIT_AW-1:0] free_bit;

  assign found     = (word != fba_pkg::FULL_WORD);
  assign last_word = ({1'b0, chk_addr} == (limit - fba_pkg::LIMIT_W'(1)));
  assign free_bit  = fba_pkg::first_zero(word);

  // Read address: the freed page's word or word 0 at acceptance, else the scan pointer
  always_comb begin
    if (state == S_IDLE) begin
      rd_addr = (operation == fba_pkg::OP_FREE) ?
                page_frame[fba_pkg::FRAME_W-1:fba_pkg::BIT_AW] : '0;
    end else begin
      rd_addr = scan_addr[fba_pkg::WORD_AW-1:0];
    end
  end

  // Write port: set the found bit, or clear the freed bit
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = word;
    case (state)
      S_SCAN: begin
        mem_we    = found;
        mem_wdata = word | (fba_pkg::WORD_BITS'(1) << free_bit);
      end
      S_FREE: begin
        mem_we    = 1'b1;
        mem_wdata = word & ~(fba_pkg::WORD_BITS'(1) << pf_bit);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // Drop the output beat once taken, unless S_DONE reloads it this cycle
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            kern_q       <= is_kernel;
            wr_q         <= is_writeable;
            pf_bit       <= page_frame[fba_pkg::BIT_AW-1:0];
            chk_addr     <= rd_addr;
            scan_addr    <= fba_pkg::LIMIT_W'(1);
            res_frame    <= '0;
            res_present  <= 1'b0;
            res_writable <= 1'b0;
            res_user     <= 1'b0;
            if (operation == fba_pkg::OP_ALLOC) begin
              if (page_frame != '0) begin
                res_status <= fba_pkg::ST_HAD_FRAME;
                res_frame  <= page_frame;
                state      <= S_DONE;
              end else if (limit == '0) begin
                res_status <= fba_pkg::ST_NO_FREE;
                state      <= S_DONE;
              end else begin
                state <= S_SCAN;
              end
            end else if (page_frame == '0) begin
              res_status <= fba_pkg::ST_NOTHING;
              state      <= S_DONE;
            end else begin
              state <= S_FREE;
            end
          end
        end
        S_SCAN: begin
          // Advance one word per cycle; the read for scan_addr is already in flight
          chk_addr  <= scan_addr[fba_pkg::WORD_AW-1:0];
          scan_addr <= scan_addr + fba_pkg::LIMIT_W'(1);
          if (found) begin
            res_status   <= fba_pkg::ST_ALLOCATED;
            res_frame    <= {chk_addr, free_bit};
            res_present  <= 1'b1;
            res_writable <= wr_q;
            res_user     <= kern_q;
            state        <= S_DONE;
          end else if (last_word) begin
            res_status <= fba_pkg::ST_NO_FREE;
            state      <= S_DONE;
          end
        end
        S_FREE: begin
          res_status <= fba_pkg::ST_FREED;
          state      <= S_DONE;
        end
        S_DONE: begin
          // Hold until the output register is free
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            status      <= res_status;
            frame_index <= res_frame;
            present     <= res_present;
            writable    <= res_writable;
            user_bit    <= res_user;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The scan never looks at a word outside the searched range
  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> ({1'b0, chk_addr} < limit))
    else $error("scan word outside searched range");

  // Only a successful allocation carries page-entry flags
  a_flags_only_on_alloc: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != fba_pkg::ST_ALLOCATED)) |-> (!present && !writable && !user_bit))
    else $error("flags set on a non-allocating result");

  // An allocation claims a bit that was clear in the word read
  a_alloc_bit_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && mem_we) |-> (word[free_bit] == 1'b0))
    else $error("allocated frame was already in use");

  // No result survives reset
  a_reset_clears_out: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

>>> tb/frame_bitmap_allocator_core_tb.sv
`timescale 1ns / 1ps

module frame_bitmap_allocator_core_tb;
  import fba_pkg::*;

  localparam int CLK_HALF    = 4;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_TAIL  = 8;

  typedef struct {
    logic               op;
    logic [FRAME_W-1:0] frame;
    logic               kern;
    logic               wr;
  } page_request_t;

  typedef struct {
    status_t            status;
    logic [FRAME_W-1:0] frame;
    logic               present;
    logic               writable;
    logic               user;
  } page_update_t;

  // DUT ports; every input is driven to a known value from time zero
  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        cfg_we       = 1'b0;
  logic [12:0] cfg_wdata    = '0;
  logic        in_valid     = 1'b0;
  logic        in_ready;
  logic        operation    = OP_ALLOC;
  logic [11:0] page_frame   = '0;
  logic        is_kernel    = 1'b0;
  logic        is_writeable = 1'b0;
  logic        out_valid;
  logic        out_ready    = 1'b0;
  logic [2:0]  status;
  logic [11:0] frame_index;
  logic        present;
  logic        writable;
  logic        user_bit;

  // Shadow of the frame bitmap and of the frame-count register
  bit [WORD_BITS-1:0] used_words [WORD_COUNT];
  logic [NF_W-1:0]    managed_frames = NUM_FRAMES_RESET;

  page_request_t pending_requests[$];
  page_update_t  expected_updates[$];
  int            held_frames[$];     // frames handed out and not yet released

  bit  req_accepted = 1'b0;          // set at the edge that took the request beat
  bit  steady_flow  = 1'b0;          // suppress all idling on both sides
  int  send_gap     = 0;
  int  stall_left   = 0;
  int  error_count  = 0;
  int  cycle_count  = 0;
  int  request_beats = 0;
  int  phase_count  = 0;
  int  status_seen [5];

  frame_bitmap_allocator_core DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .page_frame   (page_frame),
    .is_kernel    (is_kernel),
    .is_writeable (is_writeable),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .frame_index  (frame_index),
    .present      (present),
    .writable     (writable),
    .user_bit     (user_bit)
  );

  always #CLK_HALF clk = ~clk;

  // Apply one request to the shadow bitmap and return the page-entry update it causes.
  // Allocation is first fit over whole words below the frame count, capped at the bitmap.
  function automatic page_update_t predict_page_update(page_request_t req);
    page_update_t upd;
    int           limit;
    bit           found;
    upd = '{status: ST_NOTHING, frame: '0, present: 1'b0, writable: 1'b0, user: 1'b0};
    found = 1'b0;
    if (req.op == OP_ALLOC) begin
      if (req.frame != '0) begin
        upd.status = ST_HAD_FRAME;
        upd.frame  = req.frame;
      end else begin
        upd.status = ST_NO_FREE;
        limit = int'(managed_frames >> BIT_AW);
        if (limit > WORD_COUNT) limit = WORD_COUNT;
        for (int w = 0; w < limit && !found; w++) begin
          if (used_words[w] == FULL_WORD) continue;
          for (int b = 0; b < WORD_BITS && !found; b++) begin
            if (!used_words[w][b]) begin
              found          = 1'b1;
              used_words[w][b] = 1'b1;
              upd.status     = ST_ALLOCATED;
              upd.frame      = FRAME_W'(w * WORD_BITS + b);
              upd.present    = 1'b1;
              upd.writable   = req.wr;
              upd.user       = req.kern;
            end
          end
        end
      end
    end else if (req.frame != '0) begin
      // every 12-bit frame number has a bitmap word here, so always clear it
      upd.status = ST_FREED;
      used_words[req.frame >> BIT_AW][req.frame[BIT_AW-1:0]] = 1'b0;
    end
    return upd;
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  // Mostly back-to-back, sometimes a short pause, rarely a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Driver: present the next request at the falling edge; hold it until taken.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_accepted) begin
      req_accepted = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_requests.size() > 0) begin
        page_request_t req;
        req = pending_requests.pop_front();
        operation    <= req.op;
        page_frame   <= req.frame;
        is_kernel    <= req.kern;
        is_writeable <= req.wr;
        in_valid     <= 1'b1;
        send_gap     = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure: drop ready for random stretches.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!steady_flow && $urandom_range(0, 99) < 20) stall_left = pick_gap();
    end
  end

  // Monitor: predict on each request beat, check each result beat against the oldest update.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        page_request_t req;
        page_update_t  upd;
        req = '{op: operation, frame: page_frame, kern: is_kernel, wr: is_writeable};
        upd = predict_page_update(req);
        expected_updates.push_back(upd);
        if (upd.status == ST_ALLOCATED && upd.frame != '0) held_frames.push_back(int'(upd.frame));
        request_beats++;
        req_accepted = 1'b1;
      end
      if (out_valid && out_ready) begin
        if (expected_updates.size() == 0) begin
          report_mismatch($sformatf("result beat with no request outstanding (status %0d)",
                                    status));
        end else begin
          page_update_t want;
          want = expected_updates.pop_front();
          if (status < 3'd5) status_seen[status]++;
          if (status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", status, want.status));
          if (frame_index !== want.frame)
            report_mismatch($sformatf("frame_index %0d, want %0d", frame_index, want.frame));
          if (present !== want.present)
            report_mismatch($sformatf("present %0b, want %0b", present, want.present));
          if (writable !== want.writable)
            report_mismatch($sformatf("writable %0b, want %0b", writable, want.writable));
          if (user_bit !== want.user)
            report_mismatch($sformatf("user_bit %0b, want %0b", user_bit, want.user));
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Watchdog expired after %0d cycles", cycle_count);
      $display("FAILURE");
      $finish;
    end
  end

  task automatic queue_request(input logic op, input int frame, input int kern,
                               input int wr);
    page_request_t req;
    req = '{op: op, frame: FRAME_W'(frame), kern: 1'(kern), wr: 1'(wr)};
    pending_requests.push_back(req);
  endtask

  // Hold until the request queue, the handshake and the scoreboard are all empty,
  // then let the block settle.
  task automatic wait_drained();
    while (pending_requests.size() > 0 || in_valid || expected_updates.size() > 0)
      @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  // Only called while idle; the shadow register follows once the DUT has taken the write.
  task automatic write_frame_count(input int value);
    @(negedge clk);
    cfg_wdata <= NF_W'(value);
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
    managed_frames = NF_W'(value);
    phase_count++;
  endtask

  // Mix of well-formed traffic (allocate into an empty entry, release a held frame)
  // and noise (allocate into a full entry, release nothing, release an arbitrary frame).
  task automatic run_random_phase(input int frames, input int count, input int alloc_pct,
                                  input int free_pct);
    int r;
    int idx;
    write_frame_count(frames);
    for (int n = 0; n < count; n++) begin
      while (pending_requests.size() >= 3) @(posedge clk);
      r = $urandom_range(0, 99);
      if (r < alloc_pct) begin
        queue_request(OP_ALLOC, 0, $urandom_range(0, 1), $urandom_range(0, 1));
      end else if (r < alloc_pct + free_pct && held_frames.size() > 0) begin
        idx = $urandom_range(0, held_frames.size() - 1);
        queue_request(OP_FREE, held_frames[idx], $urandom_range(0, 1), $urandom_range(0, 1));
        held_frames.delete(idx);
      end else begin
        case ($urandom_range(0, 2))
          0: queue_request(OP_ALLOC, $urandom_range(1, 4095), $urandom_range(0, 1),
                           $urandom_range(0, 1));
          1: queue_request(OP_FREE, 0, $urandom_range(0, 1), $urandom_range(0, 1));
          default: queue_request(OP_FREE, $urandom_range(1, 4095), $urandom_range(0, 1),
                                 $urandom_range(0, 1));
        endcase
      end
    end
    wait_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset frame count of 4096
    queue_request(OP_FREE,  0,    1, 1);  // nothing to free
    queue_request(OP_ALLOC, 0,    1, 1);  // frame zero handed out
    queue_request(OP_ALLOC, 0,    0, 0);  // next frame up
    queue_request(OP_ALLOC, 0,    1, 0);
    queue_request(OP_ALLOC, 0,    0, 1);
    queue_request(OP_ALLOC, 4095, 1, 1);  // entry already holds a frame
    queue_request(OP_ALLOC, 2048, 0, 1);
    queue_request(OP_ALLOC, 1,    1, 0);
    queue_request(OP_FREE,  2,    0, 0);  // release and take the hole back
    queue_request(OP_ALLOC, 0,    1, 1);
    queue_request(OP_FREE,  4095, 1, 1);  // never allocated, still reports freed
    queue_request(OP_FREE,  2730, 0, 1);
    queue_request(OP_FREE,  1365, 1, 0);
    queue_request(OP_FREE,  0,    0, 0);
    queue_request(OP_ALLOC, 0,    0, 0);
    wait_drained();

    // Directed: no words searched at all, then a partial word that is still not searched
    write_frame_count(0);
    queue_request(OP_ALLOC, 0, 1, 1);     // no free frame
    queue_request(OP_ALLOC, 0, 0, 0);
    queue_request(OP_FREE,  1, 1, 1);
    queue_request(OP_ALLOC, 7, 1, 1);
    wait_drained();
    write_frame_count(31);
    queue_request(OP_ALLOC, 0, 1, 0);     // partial word is not searched
    queue_request(OP_ALLOC, 0, 0, 1);
    wait_drained();

    // Random phases over small, odd, reset and extreme frame counts
    run_random_phase(32,   60, 70, 20);
    run_random_phase(8191, 50, 60, 25);   // words searched capped at the bitmap size
    run_random_phase(96,   80, 65, 20);
    run_random_phase(63,   40, 60, 25);
    steady_flow = 1'b1;
    run_random_phase(4096, 60, 55, 30);
    steady_flow = 1'b0;
    run_random_phase(160,  80, 75, 15);
    run_random_phase(0,    15, 50, 30);
    run_random_phase($urandom_range(0, 8191), 40, 55, 30);
    run_random_phase($urandom_range(0, 8191), 40, 55, 30);

    $display("Run covered %0d requests over %0d frame-count settings in %0d cycles",
             request_beats, phase_count, cycle_count);
    $display("Results: %0d allocated, %0d already held, %0d freed, %0d nothing to free,",
             status_seen[ST_ALLOCATED], status_seen[ST_HAD_FRAME], status_seen[ST_FREED],
             status_seen[ST_NOTHING]);
    $display("         %0d exhausted", status_seen[ST_NO_FREE]);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
